FILE: rtl/core/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types and constants of the weighted symbol sampler.
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int WORD_W     = 64;
    localparam int COUNT_W    = 32;
    localparam int IDX_W      = 4;
    localparam int CFG_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int DIV_CNT_W  = $clog2(WORD_W + 1);
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_DRAW = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_CHOSEN     = 2'd0,
        ST_REJECT     = 2'd1,
        ST_ZERO_TOTAL = 2'd2,
        ST_PAST_END   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_S,
        S_MUL_LO,
        S_MUL_HI,
        S_MID,
        S_DIV,
        S_CHK,
        S_SRCH_RD,
        S_SRCH_CMP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    tbl_wr;
        logic    ld_x;
        logic    rd_last;
        logic    rd_idx;
        logic    cap_s;
        logic    mul_lo;
        logic    mul_hi;
        logic    mul_mid;
        logic    div_start;
        logic    div_step;
        logic    idx_clr;
        logic    idx_inc;
        logic    res_ld;
        logic    res_use_idx;
        t_status res_status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic s_zero;
        logic div_last;
        logic reject;
        logic hit;
        logic idx_last;
        logic out_busy;
    } t_dp_sts;

endpackage

FILE: rtl/core/wss_ram.sv
// ----------------------------------------------------------------------------
// wss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/wss_ctrl.sv
// ----------------------------------------------------------------------------
// wss_ctrl
// Sequencer for load and draw beats: multiply, remainder loop, table search.
// ----------------------------------------------------------------------------
module wss_ctrl import wss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_s_cmd,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_s_tready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_s_cmd == CMD_LOAD) begin
                        o_cmd.tbl_wr = 1'b1;
                    end else begin
                        o_cmd.ld_x    = 1'b1;
                        o_cmd.rd_last = 1'b1;
                        n_state       = S_RD_S;
                    end
                end
            end
            S_RD_S: begin
                o_cmd.cap_s = 1'b1;
                n_state     = S_MUL_LO;
            end
            S_MUL_LO: begin
                if (i_sts.s_zero) begin
                    if (!i_sts.out_busy) begin
                        o_cmd.res_ld     = 1'b1;
                        o_cmd.res_status = ST_ZERO_TOTAL;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.mul_lo = 1'b1;
                    n_state      = S_MUL_HI;
                end
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_MID;
            end
            S_MID: begin
                o_cmd.mul_mid   = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.reject) begin
                    if (!i_sts.out_busy) begin
                        o_cmd.res_ld     = 1'b1;
                        o_cmd.res_status = ST_REJECT;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                o_cmd.rd_idx = 1'b1;
                n_state      = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                // read data holds while we wait on a busy output
                if (i_sts.hit) begin
                    if (!i_sts.out_busy) begin
                        o_cmd.res_ld      = 1'b1;
                        o_cmd.res_use_idx = 1'b1;
                        o_cmd.res_status  = ST_CHOSEN;
                        n_state           = S_IDLE;
                    end
                end else if (i_sts.idx_last) begin
                    if (!i_sts.out_busy) begin
                        o_cmd.res_ld     = 1'b1;
                        o_cmd.res_status = ST_PAST_END;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SRCH_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/wss_dp.sv
// ----------------------------------------------------------------------------
// wss_dp
// Datapath: count table, shared 32x32 multiplier, bit-serial remainder,
// search index and the result register.
// ----------------------------------------------------------------------------
module wss_dp import wss_pkg::*; #(
    parameter int NUM_SYMBOLS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_cfg_wr_en,
    input  logic [CFG_W-1:0]    i_cfg_wr_data,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [COUNT_W-1:0]  i_cumulative_count,
    input  logic [WORD_W-1:0]   i_random_word,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_symbol_index
);

    localparam int AW   = $clog2(NUM_SYMBOLS);
    localparam int IW   = (AW > IDX_W) ? AW : IDX_W;
    localparam int NW   = $clog2(NUM_SYMBOLS + 1);
    localparam int CMPW = (NW > CFG_W) ? NW : CFG_W;
    localparam int HW   = WORD_W / 2;

    logic [CFG_W-1:0]    r_sym_cnt;
    logic [WORD_W-1:0]   r_x;
    logic [COUNT_W-1:0]  r_s;
    logic [WORD_W-1:0]   r_prod_lo;
    logic [WORD_W-1:0]   r_prod_hi;
    logic [WORD_W-1:0]   r_lo;
    logic [COUNT_W-1:0]  r_hi;
    logic [COUNT_W-1:0]  r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [AW-1:0]       r_idx;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [IDX_W-1:0]    r_sym;

    logic [IW-1:0]       wr_idx_ext;
    logic                wr_en;
    logic [CMPW-1:0]     cnt_ext;
    logic [CMPW-1:0]     n_active;
    logic [CMPW-1:0]     n_minus1;
    logic [AW-1:0]       last_addr;
    logic [AW-1:0]       rd_addr;
    logic [COUNT_W-1:0]  rd_data;
    logic [HW-1:0]       mul_op;
    logic [WORD_W-1:0]   mul_res;
    logic [WORD_W-1:0]   mid;
    logic [COUNT_W:0]    rem_sh;
    logic [COUNT_W:0]    rem_diff;
    logic [IW-1:0]       idx_ext;

    // load address and range check
    assign wr_idx_ext = IW'(i_entry_index);
    assign wr_en      = i_cmd.tbl_wr &&
                        ({1'b0, wr_idx_ext} < (IW + 1)'(NUM_SYMBOLS));

    // active entries: zero counts as one, saturate at the table depth
    assign cnt_ext   = CMPW'(r_sym_cnt);
    assign n_active  = (cnt_ext == '0) ? CMPW'(1) :
                       (cnt_ext > CMPW'(NUM_SYMBOLS)) ? CMPW'(NUM_SYMBOLS) : cnt_ext;
    assign n_minus1  = n_active - CMPW'(1);
    assign last_addr = n_minus1[AW-1:0];

    assign rd_addr = i_cmd.rd_last ? last_addr : r_idx;

    wss_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx_ext[AW-1:0]),
        .i_wr_data (i_cumulative_count),
        .i_rd_en   (i_cmd.rd_last | i_cmd.rd_idx),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // one 32x32 multiplier shared by both halves of the word
    assign mul_op  = i_cmd.mul_hi ? r_x[WORD_W-1:HW] : r_x[HW-1:0];
    assign mul_res = mul_op * r_s;
    assign mid     = r_prod_hi + {{HW{1'b0}}, r_prod_lo[WORD_W-1:HW]};

    // restoring remainder step over the dividend 2^64 - s
    assign rem_sh   = {r_rem, r_x[WORD_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_s};

    assign idx_ext = IW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_cnt   <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sym_cnt <= i_cfg_wr_data;
            end
            if (i_cmd.res_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_x) begin
            r_x <= i_random_word;
        end else if (i_cmd.div_start) begin
            r_x <= '0 - {{(WORD_W - COUNT_W){1'b0}}, r_s};
        end else if (i_cmd.div_step) begin
            r_x <= {r_x[WORD_W-2:0], 1'b0};
        end
        if (i_cmd.cap_s) begin
            r_s <= rd_data;
        end
        if (i_cmd.mul_lo) begin
            r_prod_lo <= mul_res;
        end
        if (i_cmd.mul_hi) begin
            r_prod_hi <= mul_res;
        end
        if (i_cmd.mul_mid) begin
            r_hi <= mid[WORD_W-1:HW];
            r_lo <= {mid[HW-1:0], r_prod_lo[HW-1:0]};
        end
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_div_cnt <= DIV_CNT_W'(WORD_W);
        end else if (i_cmd.div_step) begin
            r_rem     <= rem_diff[COUNT_W] ? rem_sh[COUNT_W-1:0] : rem_diff[COUNT_W-1:0];
            r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.res_ld) begin
            r_status <= i_cmd.res_status;
            r_sym    <= i_cmd.res_use_idx ? idx_ext[IDX_W-1:0] : '0;
        end
    end

    assign o_sts.s_zero   = (r_s == '0);
    assign o_sts.div_last = (r_div_cnt == DIV_CNT_W'(1));
    assign o_sts.reject   = (r_lo < {{(WORD_W - COUNT_W){1'b0}}, r_rem});
    assign o_sts.hit      = (r_hi < rd_data);
    assign o_sts.idx_last = (r_idx == last_addr);
    assign o_sts.out_busy = r_out_valid && !i_m_tready;

    assign o_m_tvalid     = r_out_valid;
    assign o_status       = r_status;
    assign o_symbol_index = r_sym;

endmodule

FILE: rtl/core/weighted_symbol_sampler.sv
// ----------------------------------------------------------------------------
// weighted_symbol_sampler
// Load beat: the entry is written as the beat is accepted. Draw beat: one at a
// time; zero total ends it early, else multiply, remainder, reject or search.
// The 64-step bit-serial remainder (2^64 - s) mod s sets the draw time.
// Sync active-low reset clears control and sets symbol_count to 16; the
// count table is not cleared.
// ----------------------------------------------------------------------------
module weighted_symbol_sampler import wss_pkg::*; #(
    parameter int NUM_SYMBOLS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [CFG_W-1:0]   i_cfg_wr_data,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // entry_index [3:0], cumulative_count [35:4], random_word [99:36], pad
    input  logic [103:0]       i_s_axis_tdata,
    // cmd [0]
    input  logic               i_s_axis_tuser,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // symbol_index [3:0], pad
    output logic [7:0]         o_m_axis_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0] o_m_axis_tuser
);

    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;
    logic [IDX_W-1:0] symbol_index;

    wss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_cmd    (i_s_axis_tuser),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_s_tready (o_s_axis_tready)
    );

    wss_dp #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_sts              (dp_sts),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_entry_index      (i_s_axis_tdata[3:0]),
        .i_cumulative_count (i_s_axis_tdata[35:4]),
        .i_random_word      (i_s_axis_tdata[99:36]),
        .i_m_tready         (i_m_axis_tready),
        .o_m_tvalid         (o_m_axis_tvalid),
        .o_status           (o_m_axis_tuser),
        .o_symbol_index     (symbol_index)
    );

    assign o_m_axis_tdata = {4'b0000, symbol_index};

endmodule

FILE: rtl/core/wss_checker.sv
// ----------------------------------------------------------------------------
// wss_checker
// Port-level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module wss_checker import wss_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic                i_s_axis_tuser,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [7:0]          o_m_axis_tdata,
    input logic [STATUS_W-1:0] o_m_axis_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // symbol is zero unless a symbol was chosen
    a_sym_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != ST_CHOSEN) |-> o_m_axis_tdata == 8'd0)
        else $error("symbol index set on a non-chosen result");

    // a draw occupies the block
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == CMD_DRAW) |=>
        !o_s_axis_tready)
        else $error("input ready right after a draw beat");

    // new results only come out of a busy block
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind weighted_symbol_sampler wss_checker u_wss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

FILE: tb/weighted_symbol_sampler_tb.sv
// ----------------------------------------------------------------------------
// weighted_symbol_sampler_tb
// Loads cumulative count tables and draws symbols with random words. Every
// beat accepted on the input stream is fed to a bit-accurate predictor that
// keeps its own copy of the table and the symbol_count setting. Each result
// beat is checked against the oldest predicted draw outcome.
// ----------------------------------------------------------------------------
module weighted_symbol_sampler_tb;
    import wss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SYMBOLS  = 16;
    localparam int ITEMS        = 1850;
    localparam int DRAIN_CYCLES = 110;
    localparam int CYCLE_LIMIT  = 1000000;

    // ------------------------------------------------------------------------
    // Draw predictor and result store
    // ------------------------------------------------------------------------
    class draw_scoreboard;
        typedef struct {
            t_status          status;
            logic [IDX_W-1:0] symbol;
        } t_draw_outcome;

        logic [COUNT_W-1:0] counts [NUM_SYMBOLS];
        logic [CFG_W-1:0]   symbol_count;
        t_draw_outcome      outcome_q [$];
        int                 errors;
        int                 loads;
        int                 draws;
        int                 n_chosen;
        int                 n_reject;
        int                 n_zero;

        function new();
            symbol_count = CFG_RESET;
            foreach (counts[i]) counts[i] = '0;
            errors   = 0;
            loads    = 0;
            draws    = 0;
            n_chosen = 0;
            n_reject = 0;
            n_zero   = 0;
        endfunction

        function void set_symbol_count(logic [CFG_W-1:0] v);
            symbol_count = v;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void note_beat(t_cmd cmd, logic [IDX_W-1:0] idx,
                                logic [COUNT_W-1:0] cnt, logic [WORD_W-1:0] word);
            int unsigned        n;
            logic [COUNT_W-1:0] total;
            logic [95:0]        prod;
            logic [64:0]        thresh;
            t_draw_outcome      outcome;
            if (cmd == CMD_LOAD) begin
                if (int'(idx) < NUM_SYMBOLS) counts[idx] = cnt;
                loads++;
                return;
            end
            draws++;
            if (symbol_count == '0) n = 1;
            else if (int'(symbol_count) > NUM_SYMBOLS) n = NUM_SYMBOLS;
            else n = int'(symbol_count);
            total = counts[n-1];
            outcome.symbol = '0;
            if (total == '0) begin
                outcome.status = ST_ZERO_TOTAL;
                n_zero++;
            end else begin
                prod   = {32'd0, word} * {64'd0, total};
                // (2^64 - s) mod s, the Lemire rejection threshold
                thresh = ({1'b1, 64'd0} - {33'd0, total}) % {33'd0, total};
                if (prod[63:0] < thresh[63:0]) begin
                    outcome.status = ST_REJECT;
                    n_reject++;
                end else begin
                    outcome.status = ST_PAST_END;
                    for (int i = 0; i < n; i++) begin
                        if (prod[95:64] < counts[i]) begin
                            outcome.status = ST_CHOSEN;
                            outcome.symbol = IDX_W'(i);
                            break;
                        end
                    end
                    if (outcome.status == ST_CHOSEN) n_chosen++;
                end
            end
            outcome_q.push_back(outcome);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [IDX_W-1:0] symbol);
            t_draw_outcome outcome;
            if (outcome_q.size() == 0) begin
                $error("unexpected result beat: status %0d symbol_index %0d", status, symbol);
                errors++;
                return;
            end
            outcome = outcome_q.pop_front();
            if (status !== outcome.status) begin
                $error("status: expected %0d, actual %0d", outcome.status, status);
                errors++;
            end
            if (symbol !== outcome.symbol) begin
                $error("symbol_index: expected %0d, actual %0d", outcome.symbol, symbol);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT
    // ------------------------------------------------------------------------
    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [CFG_W-1:0]    i_cfg_wr_data;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    // entry_index [3:0], cumulative_count [35:4], random_word [99:36], pad
    logic [103:0]        i_s_axis_tdata;
    // cmd [0]
    logic                i_s_axis_tuser;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    // symbol_index [3:0], pad
    logic [7:0]          o_m_axis_tdata;
    // status [1:0]
    logic [STATUS_W-1:0] o_m_axis_tuser;

    weighted_symbol_sampler #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    draw_scoreboard sb;
    logic           quiet;          // no idling on either side near the end
    int             cfg_writes;
    int             cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: random stall bursts
    initial begin
        int stall;
        stall = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0 && !quiet) begin
                i_m_axis_tready = 1'b0;
                stall--;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                i_m_axis_tready = 1'b0;
                stall = int'($urandom_range(1, 10)) - 1;
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tuser, o_m_axis_tdata[IDX_W-1:0]);
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_symbol_count(logic [CFG_W-1:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        sb.set_symbol_count(v);
        cfg_writes++;
    endtask

    task automatic send_beat(t_cmd cmd, logic [IDX_W-1:0] idx,
                             logic [COUNT_W-1:0] cnt, logic [WORD_W-1:0] word);
        int gap;
        gap = (!quiet && $urandom_range(0, 7) == 0) ? int'($urandom_range(1, 10)) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = cmd;
        i_s_axis_tdata  = {4'd0, word, cnt, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_beat(cmd, idx, cnt, word);
    endtask

    task automatic load(logic [IDX_W-1:0] idx, logic [COUNT_W-1:0] cnt);
        send_beat(CMD_LOAD, idx, cnt, {$urandom, $urandom});
    endtask

    task automatic draw(logic [WORD_W-1:0] word);
        send_beat(CMD_DRAW, IDX_W'($urandom_range(0, 15)), $urandom, word);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [32:0]       acc;
        logic [CFG_W-1:0]  cfg;
        logic [WORD_W-1:0] word;
        int                n;
        int                kind;
        int                nd;

        sb              = new();
        quiet           = 1'b0;
        cfg_writes      = 0;
        cycles          = 0;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tuser  = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: full table with the largest total, then edge words
        write_symbol_count(CFG_W'(16));
        for (int i = 0; i < 15; i++)
            load(IDX_W'(i), (COUNT_W'(i + 1) << 28) - COUNT_W'(1));
        load(IDX_W'(15), 32'hFFFF_FFFF);
        draw('0);                           // low product 0, below threshold
        draw(64'd1);                        // first symbol
        draw('1);                           // top of range, last symbol
        draw(64'h8000_0000_0000_0000);
        // zero count acts as one entry
        write_symbol_count(CFG_W'(0));
        draw('1);
        load(IDX_W'(0), '0);
        draw({$urandom, $urandom});         // zero total
        // oversize count saturates; total of one has no rejection
        write_symbol_count(CFG_W'(31));
        draw({$urandom, $urandom});
        load(IDX_W'(15), 32'd1);
        draw('1);

        // random phases: new setting, new table, a run of draws
        while (sb.loads + sb.draws < ITEMS) begin
            quiet = (sb.loads + sb.draws) > ITEMS - 250;
            case ($urandom_range(0, 9))
                0:       cfg = '0;
                1:       cfg = CFG_W'($urandom_range(17, 31));
                2:       cfg = CFG_W'(16);
                3:       cfg = CFG_W'(1);
                default: cfg = CFG_W'($urandom_range(1, 16));
            endcase
            write_symbol_count(cfg);
            n = (cfg == '0) ? 1 : ((int'(cfg) > NUM_SYMBOLS) ? NUM_SYMBOLS : int'(cfg));
            // 0-5 cumulative, 6-7 tiny steps, 8 arbitrary, 9 zero total
            kind = int'($urandom_range(0, 9));
            acc  = '0;
            for (int i = 0; i < n; i++) begin
                if (kind >= 8)
                    acc = {1'b0, $urandom};
                else if (kind >= 6)
                    acc = acc + 33'($urandom_range(0, 1));
                else
                    acc = acc + 33'($urandom >> $urandom_range(3, 31));
                if (acc[32]) acc = 33'h0_FFFF_FFFF;
                if (kind == 9 && i == n - 1) acc = '0;
                load(IDX_W'(i), acc[31:0]);
            end
            nd = int'($urandom_range(10, 50));
            repeat (nd) begin
                // stray overwrite breaks the cumulative shape now and then
                if ($urandom_range(0, 24) == 0)
                    load(IDX_W'($urandom_range(0, 15)), $urandom);
                case ($urandom_range(0, 19))
                    0:       word = '0;
                    1:       word = '1;
                    2:       word = {32'd0, $urandom};
                    default: word = {$urandom, $urandom};
                endcase
                draw(word);
            end
        end

        wait_drained();
        $display("covered %0d load beats and %0d draw beats over %0d symbol_count settings",
                 sb.loads, sb.draws, cfg_writes);
        $display("draw outcomes: %0d chosen, %0d rejected, %0d zero total",
                 sb.n_chosen, sb.n_reject, sb.n_zero);
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
